### src/mp2hd_pkg.sv
// Shared types, constants and frame length tables for the Layer II header decoder.
package mp2hd_pkg;

    localparam int OffsetBitsDefault = 32;
    localparam int LenW              = 11;
    localparam int AddrW             = 3;

    localparam logic [AddrW-1:0] RegMaxFrame     = 3'd0;
    localparam logic [LenW-1:0]  MaxFrameReset   = 11'd1729;

    localparam logic [7:0] SyncByte  = 8'hFF;
    localparam logic [7:0] SyncMaskB = 8'hF6;
    localparam logic [7:0] SyncValB  = 8'hF4;

    // floor(144000 * kbps / Hz), row = rate index, column = bitrate index - 1
    localparam logic [LenW-1:0] LenFull [0:2][0:13] = '{
        '{11'd104, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313, 11'd365,
          11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd1253},
        '{11'd96,  11'd144, 11'd168, 11'd192, 11'd240, 11'd288, 11'd336,
          11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960,  11'd1152},
        '{11'd144, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432, 11'd504,
          11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd1728}
    };

    localparam logic [LenW-1:0] LenLow [0:2][0:13] = '{
        '{11'd52,  11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
          11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940,  11'd1044},
        '{11'd48,  11'd96,  11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
          11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864,  11'd960},
        '{11'd72,  11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
          11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440}
    };

    typedef struct packed {
        logic            padding_flag;
        logic [1:0]      rate_code;
        logic            is_mpeg_one;
        logic [1:0]      channel_count;
        logic            length_fits;
        logic [LenW-1:0] frame_length;
        logic            header_valid;
    } t_hdr_info;

    // Nominal (unpadded) length; 0 for reserved bitrate or rate codes
    function automatic logic [LenW-1:0] nominal_len(input logic       ver,
                                                    input logic [3:0] br,
                                                    input logic [1:0] rate);
        logic [3:0]      col;
        logic [LenW-1:0] len;
        col = br - 4'd1;
        len = '0;
        if (br != 4'd0 && br != 4'd15 && rate != 2'd3) begin
            len = ver ? LenFull[rate][col] : LenLow[rate][col];
        end
        return len;
    endfunction

endpackage

### src/mp2hd_front.sv
// Header field decode, length lookup and divider setup stage.
module mp2hd_front
    import mp2hd_pkg::*;
#(
    parameter int OFFSET_BITS = OffsetBitsDefault,
    localparam int DW = OFFSET_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte_a,
    input  logic [7:0]       i_byte_b,
    input  logic [7:0]       i_byte_c,
    input  logic [7:0]       i_byte_d,
    input  logic [OFFSET_BITS-1:0] i_offset,
    input  logic [LenW-1:0]  i_max_frame,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [DW-1:0]    o_dq,
    output logic [LenW-1:0]  o_div,
    output t_hdr_info        o_info
);

    logic            r_valid;
    logic [DW-1:0]   r_dq;
    logic [LenW-1:0] r_div;
    t_hdr_info       r_info;

    logic            n_synced;
    logic            n_hdr_ok;
    logic [LenW-1:0] n_nominal;
    logic [LenW-1:0] n_length;
    t_hdr_info       n_info;

    always_comb begin
        n_synced  = (i_byte_a == SyncByte) && ((i_byte_b & SyncMaskB) == SyncValB);
        n_nominal = nominal_len(i_byte_b[3], i_byte_c[7:4], i_byte_c[3:2]);
        n_hdr_ok  = n_synced && (n_nominal != '0);
        n_length  = n_nominal + LenW'(i_byte_c[1]);

        n_info.header_valid  = n_hdr_ok;
        n_info.frame_length  = n_hdr_ok ? n_length : '0;
        n_info.length_fits   = n_hdr_ok && (n_length <= i_max_frame);
        n_info.channel_count = !n_synced ? 2'd0 : ((i_byte_d[7:6] == 2'b11) ? 2'd1 : 2'd2);
        n_info.is_mpeg_one   = i_byte_b[3];
        n_info.rate_code     = i_byte_c[3:2];
        n_info.padding_flag  = i_byte_c[1];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // invalid header divides 0 by 1 so the quotient comes out 0
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_info <= n_info;
            r_div  <= n_hdr_ok ? n_nominal : LenW'(1);
            r_dq   <= n_hdr_ok ? ({1'b0, i_offset} + DW'(n_nominal[LenW-1:1])) : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_dq    = r_dq;
    assign o_div   = r_div;
    assign o_info  = r_info;

endmodule

### src/mp2hd_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes on.
module mp2hd_div_cell
    import mp2hd_pkg::*;
#(
    parameter int DW = OffsetBitsDefault + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [LenW-1:0] i_rem,
    input  logic [DW-1:0]   i_dq,
    input  logic [LenW-1:0] i_div,
    input  t_hdr_info       i_info,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [LenW-1:0] o_rem,
    output logic [DW-1:0]   o_dq,
    output logic [LenW-1:0] o_div,
    output t_hdr_info       o_info
);

    logic            r_valid;
    logic [LenW-1:0] r_rem;
    logic [DW-1:0]   r_dq;
    logic [LenW-1:0] r_div;
    t_hdr_info       r_info;

    logic [LenW:0]   n_trial;
    logic            n_ge;
    logic [LenW-1:0] n_rem;

    // dq holds the untouched dividend bits on top, quotient bits shift in below
    always_comb begin
        n_trial = {i_rem, i_dq[DW-1]};
        n_ge    = n_trial >= {1'b0, i_div};
        n_rem   = n_ge ? LenW'(n_trial - {1'b0, i_div}) : n_trial[LenW-1:0];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rem  <= n_rem;
            r_dq   <= {i_dq[DW-2:0], n_ge};
            r_div  <= i_div;
            r_info <= i_info;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_div   = r_div;
    assign o_info  = r_info;

endmodule

### src/mpeg_layer2_header_decode_top.sv
// Top level of the MPEG audio Layer II header decoder: APB register, decode stage, divider chain.
// Takes one candidate header per clock while the output is not stalled and returns one result per
// header, in order. There is one decode stage, then a chain of OFFSET_BITS + 1 division cells,
// each resolving one bit of the rounded frame number. Every stage has its own valid and hands its
// item on when the next stage is free, so gaps fill while the output stalls. max_frame_bytes sits
// at APB address 0 (reset 1729) and must be written while idle.
module mpeg_layer2_header_decode_top
    import mp2hd_pkg::*;
#(
    parameter int OFFSET_BITS = OffsetBitsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // APB configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // tdata: head_byte_a[7:0], head_byte_b[15:8], head_byte_c[23:16], head_byte_d[31:24],
    //        stream_offset[63:32]
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [63:0]      i_s_tdata,
    // tdata: header_valid[0], frame_length[11:1], length_fits[12], channel_count[14:13],
    //        is_mpeg_one[15], rate_code[17:16], padding_flag[18], frame_number[50:19], zero[55:51]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [55:0]      o_m_tdata
);

    localparam int DW = OFFSET_BITS + 1;

    logic [LenW-1:0] r_max_frame;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MaxFrameReset;
        end else if (psel && penable && pwrite && pready && paddr == RegMaxFrame) begin
            r_max_frame <= pwdata[LenW-1:0];
        end
    end

    assign prdata = (paddr == RegMaxFrame) ? {(32 - LenW)'(0), r_max_frame} : '0;

    // chain links: index 0 is the decode stage output, index DW the last cell
    logic            c_valid [0:DW];
    logic            c_ready [0:DW];
    logic [LenW-1:0] c_rem   [0:DW];
    logic [DW-1:0]   c_dq    [0:DW];
    logic [LenW-1:0] c_div   [0:DW];
    t_hdr_info       c_info  [0:DW];

    mp2hd_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_byte_a    (i_s_tdata[7:0]),
        .i_byte_b    (i_s_tdata[15:8]),
        .i_byte_c    (i_s_tdata[23:16]),
        .i_byte_d    (i_s_tdata[31:24]),
        .i_offset    (i_s_tdata[32 +: OFFSET_BITS]),
        .i_max_frame (r_max_frame),
        .o_valid     (c_valid[0]),
        .i_ready     (c_ready[0]),
        .o_dq        (c_dq[0]),
        .o_div       (c_div[0]),
        .o_info      (c_info[0])
    );

    assign c_rem[0] = '0;

    for (genvar k = 0; k < DW; k++) begin : g_cell
        mp2hd_div_cell #(
            .DW (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_rem   (c_rem[k]),
            .i_dq    (c_dq[k]),
            .i_div   (c_div[k]),
            .i_info  (c_info[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_dq    (c_dq[k+1]),
            .o_div   (c_div[k+1]),
            .o_info  (c_info[k+1])
        );
    end

    assign c_ready[DW] = i_m_tready;
    assign o_m_tvalid  = c_valid[DW];
    assign o_m_tdata   = {5'b0, 32'(c_dq[DW]), c_info[DW]};

endmodule
